/* design/swk_pkg.sv */
package swk_pkg;

  localparam int DirW      = 22;
  localparam int RotVW     = 34;
  localparam int TermW     = 32;
  localparam int AngW      = 34;
  localparam int TgtW      = 22;
  localparam int DrvW      = 20;
  localparam int NowW      = 33;
  localparam int DivStages = 32;

  localparam longint PiQ30     = 64'sd3373259426;
  localparam longint TwoPiQ30  = 2 * PiQ30;
  localparam longint HalfPiQ30 = PiQ30 / 2;
  localparam longint GainQ24   = 64'sd10188014;

  localparam logic signed [AngW-1:0] AtanQ30 [24] = '{
    34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
    34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
    34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
    34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
    34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
    34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F
  };

  typedef enum logic [2:0] {
    RegAbsoluteMode  = 3'd0,
    RegFrontToBack   = 3'd1,
    RegLeftToRight   = 3'd2,
    RegMaxRotation   = 3'd3,
    RegSteerRatio    = 3'd4,
    RegMaxSteer      = 3'd5,
    RegMaxDriveSpeed = 3'd6
  } swk_reg_e;

  typedef struct packed {
    logic signed [RotVW-1:0] vx;
    logic signed [RotVW-1:0] vy;
    logic signed [TermW-1:0] tx;
    logic signed [TermW-1:0] ty;
    logic signed [DirW-1:0]  dir;
    logic                    moving;
  } swk_rot_t;

  function automatic longint pi_f(int f);
    return (PiQ30 + (64'sd1 << (29 - f))) >>> (30 - f);
  endfunction

  function automatic longint half_pi_f(int f);
    return (PiQ30 + (64'sd1 << (30 - f))) >>> (31 - f);
  endfunction

  function automatic longint three_half_pi_f(int f);
    return (3 * PiQ30 + (64'sd1 << (30 - f))) >>> (31 - f);
  endfunction

  function automatic int rot_lat(int n);
    return n + 3;
  endfunction

  function automatic int main_lat(int n);
    return rot_lat(n) + n + 3;
  endfunction

  function automatic int join_lat(int n);
    return (main_lat(n) > DivStages) ? main_lat(n) : DivStages;
  endfunction

  function automatic int pipe_lat(int n);
    return join_lat(n) + 3;
  endfunction

endpackage

/* design/swk_rotate.sv */
module swk_rotate #(
  parameter int AngleFracBits = 13,
  parameter int NStages       = 16
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [15:0]                speed_i,
  input  logic signed [swk_pkg::DirW-1:0]   dir_i,
  input  logic signed [15:0]                rot_i,
  input  logic                              moving_i,
  input  logic [15:0]                       ftb_i,
  input  logic [15:0]                       ltr_i,
  output swk_pkg::swk_rot_t                 rot_o
);
  import swk_pkg::*;

  localparam int AW   = DirW + 30 - AngleFracBits;
  localparam int KMax = DirW - AngleFracBits - 4;
  localparam logic [AW-1:0] TwoPiA = AW'(TwoPiQ30);

  logic [AW-1:0]           mag;
  logic signed [AW-1:0]    a_full;
  logic signed [33:0]      m34;
  logic signed [33:0]      a1_d;
  logic signed [32:0]      pf;
  logic signed [32:0]      pl;

  logic signed [33:0]      a1_q;
  logic signed [15:0]      speed1_q;
  logic signed [TermW-1:0] tx1_q, ty1_q;
  logic signed [DirW-1:0]  dir1_q;
  logic                    mov1_q;

  always_comb begin
    a_full = AW'(dir_i) <<< (30 - AngleFracBits);
    mag = a_full[AW-1] ? AW'(-a_full) : AW'(a_full);
    for (int k = KMax; k >= 0; k--) begin
      if (mag >= (TwoPiA << k)) begin
        mag = mag - (TwoPiA << k);
      end
    end
    m34 = $signed(34'(mag));
    a1_d = a_full[AW-1] ? -m34 : m34;
    pf = 33'(rot_i) * 33'($signed({1'b0, ftb_i}));
    pl = 33'(rot_i) * 33'($signed({1'b0, ltr_i}));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q     <= a1_d;
      speed1_q <= speed_i;
      tx1_q    <= pf[32:1];
      ty1_q    <= pl[32:1];
      dir1_q   <= dir_i;
      mov1_q   <= moving_i;
    end
  end

  logic signed [34:0]      a2;
  logic                    neg2;
  logic signed [40:0]      px;

  logic signed [RotVW-1:0] x_q   [NStages+1];
  logic signed [RotVW-1:0] y_q   [NStages+1];
  logic signed [AngW-1:0]  z_q   [NStages+1];
  logic                    neg_q [NStages+1];
  logic signed [TermW-1:0] tx_q  [NStages+1];
  logic signed [TermW-1:0] ty_q  [NStages+1];
  logic signed [DirW-1:0]  dir_q [NStages+1];
  logic                    mov_q [NStages+1];

  always_comb begin
    a2 = 35'(a1_q);
    neg2 = 1'b0;
    if (a2 > 35'(PiQ30)) begin
      a2 = a2 - 35'(TwoPiQ30);
    end
    if (a2 <= -35'(PiQ30)) begin
      a2 = a2 + 35'(TwoPiQ30);
    end
    if (a2 > 35'(HalfPiQ30)) begin
      a2 = a2 - 35'(PiQ30);
      neg2 = 1'b1;
    end else if (a2 < -35'(HalfPiQ30)) begin
      a2 = a2 + 35'(PiQ30);
      neg2 = 1'b1;
    end
    px = 41'(speed1_q) * 41'(GainQ24);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= RotVW'($signed(px[39:8]));
      y_q[0]   <= '0;
      z_q[0]   <= AngW'(a2);
      neg_q[0] <= neg2;
      tx_q[0]  <= tx1_q;
      ty_q[0]  <= ty1_q;
      dir_q[0] <= dir1_q;
      mov_q[0] <= mov1_q;
    end
  end

  for (genvar i = 0; i < NStages; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - AtanQ30[i];
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + AtanQ30[i];
        end
        neg_q[i+1] <= neg_q[i];
        tx_q[i+1]  <= tx_q[i];
        ty_q[i+1]  <= ty_q[i];
        dir_q[i+1] <= dir_q[i];
        mov_q[i+1] <= mov_q[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rot_o.vx     <= neg_q[NStages] ? -x_q[NStages] : x_q[NStages];
      rot_o.vy     <= neg_q[NStages] ? -y_q[NStages] : y_q[NStages];
      rot_o.tx     <= tx_q[NStages];
      rot_o.ty     <= ty_q[NStages];
      rot_o.dir    <= dir_q[NStages];
      rot_o.moving <= mov_q[NStages];
    end
  end

endmodule

/* design/swk_lane.sv */
module swk_lane #(
  parameter int   AngleFracBits = 13,
  parameter int   NStages       = 16,
  parameter logic XNeg          = 1'b0,
  parameter logic YNeg          = 1'b0
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  swk_pkg::swk_rot_t  rot_i,
  input  logic signed [23:0] steer_now_i,
  input  logic [13:0]        ratio_i,
  input  logic [22:0]        max_steer_i,
  input  logic [14:0]        max_drive_i,
  output logic signed [23:0] steer_goal_o,
  output logic signed [15:0] drive_goal_o
);
  import swk_pkg::*;

  localparam int VW = 36;
  localparam int ZW = 35;
  localparam int MainLat = main_lat(NStages);
  localparam int JoinLat = join_lat(NStages);
  localparam int DM = JoinLat - MainLat;
  localparam int DQ = JoinLat - DivStages;
  localparam int PW = TgtW + DrvW;
  localparam logic signed [ZW-1:0] TRnd = ZW'(64'sd1 << (29 - AngleFracBits));
  localparam logic signed [33:0] PiF    = 34'(pi_f(AngleFracBits));
  localparam logic signed [33:0] HalfF  = 34'(half_pi_f(AngleFracBits));
  localparam logic signed [33:0] ThreeF = 34'(three_half_pi_f(AngleFracBits));

  // Vectoring front end.
  logic signed [VW-1:0] xs, ys;
  logic signed [ZW-1:0] zs;
  logic                 zero_d;

  always_comb begin
    xs = XNeg ? VW'(rot_i.vx) - VW'(rot_i.tx) : VW'(rot_i.vx) + VW'(rot_i.tx);
    ys = YNeg ? VW'(rot_i.vy) - VW'(rot_i.ty) : VW'(rot_i.vy) + VW'(rot_i.ty);
    zero_d = (xs == 0) && (ys == 0);
    zs = '0;
    if (xs < 0) begin
      zs = (ys >= 0) ? ZW'(PiQ30) : -ZW'(PiQ30);
      xs = -xs;
      ys = -ys;
    end
  end

  logic signed [VW-1:0]   x_q    [NStages+1];
  logic signed [VW-1:0]   y_q    [NStages+1];
  logic signed [ZW-1:0]   z_q    [NStages+1];
  logic                   zero_q [NStages+1];
  logic                   mov_q  [NStages+1];
  logic signed [DirW-1:0] dir_q  [NStages+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= xs;
      y_q[0]    <= ys;
      z_q[0]    <= zs;
      zero_q[0] <= zero_d;
      mov_q[0]  <= rot_i.moving;
      dir_q[0]  <= rot_i.dir;
    end
  end

  for (genvar i = 0; i < NStages; i++) begin : g_stage
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + ZW'(AtanQ30[i]);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - ZW'(AtanQ30[i]);
        end
        zero_q[i+1] <= zero_q[i];
        mov_q[i+1]  <= mov_q[i];
        dir_q[i+1]  <= dir_q[i];
      end
    end
  end

  // Magnitude gain correction and angle rounding.
  logic signed [60:0]     magp_q;
  logic signed [ZW-1:0]   zm_q;
  logic                   zerom_q, movm_q;
  logic signed [DirW-1:0] dirm_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      magp_q  <= 61'(x_q[NStages]) * 61'(GainQ24);
      zm_q    <= z_q[NStages];
      zerom_q <= zero_q[NStages];
      movm_q  <= mov_q[NStages];
      dirm_q  <= dir_q[NStages];
    end
  end

  logic signed [60:0]     vsum;
  logic signed [ZW-1:0]   tsum;
  logic signed [TgtW-1:0] t_d;
  logic signed [DrvW-1:0] v_d;
  logic [PW-1:0]          main_q;

  always_comb begin
    vsum = (magp_q + 61'sd549755813888) >>> 40;
    tsum = (zm_q + TRnd) >>> (30 - AngleFracBits);
    t_d = TgtW'(tsum);
    v_d = vsum[DrvW-1:0];
    if (!movm_q) begin
      t_d = dirm_q;
      v_d = '0;
    end else if (zerom_q) begin
      t_d = '0;
      v_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      main_q <= {t_d, v_d};
    end
  end

  // Measured position divided by the steering ratio, one quotient bit per stage.
  logic [13:0]    dvs;
  logic [31:0]    work0;
  logic [13:0]    rem_q  [DivStages+1];
  logic [31:0]    work_q [DivStages+1];
  logic           dneg_q [DivStages+1];
  logic [23:0]    abs_now;

  always_comb begin
    dvs = (ratio_i == '0) ? 14'd1 : ratio_i;
    abs_now = steer_now_i[23] ? 24'(-steer_now_i) : 24'(steer_now_i);
    work0 = {abs_now, 8'd0};
  end

  for (genvar k = 1; k <= DivStages; k++) begin : g_div
    logic [13:0] rin;
    logic [31:0] win;
    logic        nin;
    logic [14:0] trial;
    if (k == 1) begin : g_first
      assign rin = '0;
      assign win = work0;
      assign nin = steer_now_i[23];
    end else begin : g_next
      assign rin = rem_q[k-1];
      assign win = work_q[k-1];
      assign nin = dneg_q[k-1];
    end
    assign trial = {rin, win[31]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (trial >= {1'b0, dvs}) begin
          rem_q[k]  <= 14'(trial - {1'b0, dvs});
          work_q[k] <= {win[30:0], 1'b1};
        end else begin
          rem_q[k]  <= trial[13:0];
          work_q[k] <= {win[30:0], 1'b0};
        end
        dneg_q[k] <= nin;
      end
    end
  end

  logic signed [NowW-1:0] now_d;
  assign now_d = dneg_q[DivStages] ? -$signed({1'b0, work_q[DivStages]})
                                   : $signed({1'b0, work_q[DivStages]});

  logic [PW-1:0]          main_j;
  logic signed [NowW-1:0] now_j;

  if (DM == 0) begin : g_no_dm
    assign main_j = main_q;
  end else begin : g_dm
    logic [PW-1:0] dl_q [DM];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dl_q[0] <= main_q;
        for (int j = 1; j < DM; j++) begin
          dl_q[j] <= dl_q[j-1];
        end
      end
    end
    assign main_j = dl_q[DM-1];
  end

  if (DQ == 0) begin : g_no_dq
    assign now_j = now_d;
  end else begin : g_dq
    logic signed [NowW-1:0] dl_q [DQ];
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dl_q[0] <= now_d;
        for (int j = 1; j < DQ; j++) begin
          dl_q[j] <= dl_q[j-1];
        end
      end
    end
    assign now_j = dl_q[DQ-1];
  end

  // Minor-arc choice, ratio scaling and limits.
  logic signed [TgtW-1:0] tj;
  logic signed [DrvW-1:0] vj;
  logic signed [33:0]     delta, adelta;
  logic signed [TgtW:0]   t1_d;
  logic signed [DrvW-1:0] v1_d;
  logic signed [TgtW:0]   t1_q;
  logic signed [DrvW-1:0] v1_q, v2_q;
  logic signed [37:0]     prod_q;

  always_comb begin
    tj = $signed(main_j[PW-1:DrvW]);
    vj = $signed(main_j[DrvW-1:0]);
    delta = 34'(tj) - 34'(now_j);
    adelta = (delta < 0) ? -delta : delta;
    t1_d = (TgtW+1)'(tj);
    v1_d = vj;
    if (adelta > HalfF && adelta < ThreeF) begin
      t1_d = (tj < 0) ? t1_d + (TgtW+1)'(PiF) : t1_d - (TgtW+1)'(PiF);
      v1_d = -vj;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t1_q   <= t1_d;
      v1_q   <= v1_d;
      prod_q <= 38'(t1_q) * 38'($signed({1'b0, ratio_i}));
      v2_q   <= v1_q;
    end
  end

  logic signed [37:0]     g, ms, sg;
  logic signed [DrvW-1:0] md, sv;

  always_comb begin
    g = (prod_q + 38'sd128) >>> 8;
    ms = $signed({15'd0, max_steer_i});
    if (g > ms) begin
      sg = ms;
    end else if (g < -ms) begin
      sg = -ms;
    end else begin
      sg = g;
    end
    md = $signed({5'd0, max_drive_i});
    if (v2_q > md) begin
      sv = md;
    end else if (v2_q < -md) begin
      sv = -md;
    end else begin
      sv = v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      steer_goal_o <= sg[23:0];
      drive_goal_o <= sv[15:0];
    end
  end

endmodule

/* design/swerve_wheel_kinematics_unit.sv */
// Accepts one transaction per cycle while in_stall_o is low; one shared rotation CORDIC pipeline
// feeds four wheel lanes, each with its own vectoring CORDIC pipeline and a 32-stage divider.
// While a result waits in the output register, the pipeline keeps accepting only as long as
// its last stage holds no valid transaction.
// Reset clears all valid flags and loads the configuration registers with their defaults.
module swerve_wheel_kinematics_unit #(
  parameter int ANGLE_FRAC_BITS = 13,
  parameter int CORDIC_STAGES   = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [22:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] chassis_speed_i,
  input  logic signed [15:0] heading_i,
  input  logic signed [15:0] rotation_i,
  input  logic signed [15:0] yaw_i,
  input  logic signed [23:0] steer_now_a_i,
  input  logic signed [23:0] steer_now_b_i,
  input  logic signed [23:0] steer_now_c_i,
  input  logic signed [23:0] steer_now_d_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] steer_goal_a_o,
  output logic signed [23:0] steer_goal_b_o,
  output logic signed [23:0] steer_goal_c_o,
  output logic signed [23:0] steer_goal_d_o,
  output logic signed [15:0] drive_goal_a_o,
  output logic signed [15:0] drive_goal_b_o,
  output logic signed [15:0] drive_goal_c_o,
  output logic signed [15:0] drive_goal_d_o
);
  import swk_pkg::*;

  localparam int PipeLat = pipe_lat(CORDIC_STAGES);
  localparam logic signed [DirW-1:0] PiF   = DirW'(pi_f(ANGLE_FRAC_BITS));
  localparam logic signed [DirW-1:0] HalfF = DirW'(half_pi_f(ANGLE_FRAC_BITS));

  logic        abs_mode_q;
  logic [15:0] ftb_q, ltr_q;
  logic [14:0] max_rot_q;
  logic [13:0] ratio_q;
  logic [22:0] max_steer_q;
  logic [14:0] max_drive_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_mode_q  <= 1'b0;
      ftb_q       <= 16'd4096;
      ltr_q       <= 16'd4096;
      max_rot_q   <= 15'd16384;
      ratio_q     <= 14'd256;
      max_steer_q <= 23'h7FFFFF;
      max_drive_q <= 15'h7FFF;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (swk_reg_e'(cfg_index_i))
        RegAbsoluteMode:  abs_mode_q  <= cfg_data_i[0];
        RegFrontToBack:   ftb_q       <= cfg_data_i[15:0];
        RegLeftToRight:   ltr_q       <= cfg_data_i[15:0];
        RegMaxRotation:   max_rot_q   <= cfg_data_i[14:0];
        RegSteerRatio:    ratio_q     <= cfg_data_i[13:0];
        RegMaxSteer:      max_steer_q <= cfg_data_i[22:0];
        RegMaxDriveSpeed: max_drive_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  logic valid_q [PipeLat+1];
  logic en;
  logic out_load;
  logic out_valid_q;

  assign out_load = !out_valid_q || !out_stall_i;
  assign en = !valid_q[PipeLat] || out_load;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= PipeLat; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (en) begin
      valid_q[0] <= in_valid_i;
      for (int k = 1; k <= PipeLat; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  logic signed [DirW-1:0] off, dir_d;
  logic signed [16:0]     lim, rot_x;
  logic signed [15:0]     rot_d;

  always_comb begin
    off = DirW'(yaw_i) - HalfF;
    if (off > PiF) begin
      off = off - (PiF <<< 1);
    end
    dir_d = abs_mode_q ? DirW'(heading_i) - off : DirW'(heading_i);
    lim = $signed({2'b00, max_rot_q});
    rot_x = 17'(rotation_i);
    if (rot_x > lim) begin
      rot_x = lim;
    end else if (rot_x < -lim) begin
      rot_x = -lim;
    end
    rot_d = rot_x[15:0];
  end

  logic signed [15:0]     speed_q, rot_q;
  logic signed [DirW-1:0] dir_q;
  logic                   mov_q;
  logic signed [23:0]     now_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      speed_q  <= chassis_speed_i;
      dir_q    <= dir_d;
      rot_q    <= rot_d;
      mov_q    <= (chassis_speed_i != 0) || (rot_d != 0);
      now_q[0] <= steer_now_a_i;
      now_q[1] <= steer_now_b_i;
      now_q[2] <= steer_now_c_i;
      now_q[3] <= steer_now_d_i;
    end
  end

  swk_rot_t rot_v;

  swk_rotate #(
    .AngleFracBits(ANGLE_FRAC_BITS),
    .NStages      (CORDIC_STAGES)
  ) u_rotate (
    .clk_i   (clk_i),
    .en_i    (en),
    .speed_i (speed_q),
    .dir_i   (dir_q),
    .rot_i   (rot_q),
    .moving_i(mov_q),
    .ftb_i   (ftb_q),
    .ltr_i   (ltr_q),
    .rot_o   (rot_v)
  );

  logic signed [23:0] steer_l [4];
  logic signed [15:0] drive_l [4];
  logic signed [23:0] steer_o_q [4];
  logic signed [15:0] drive_o_q [4];

  for (genvar w = 0; w < 4; w++) begin : g_lane
    swk_lane #(
      .AngleFracBits(ANGLE_FRAC_BITS),
      .NStages      (CORDIC_STAGES),
      .XNeg         (w < 2),
      .YNeg         ((w == 0) || (w == 2))
    ) u_lane (
      .clk_i       (clk_i),
      .en_i        (en),
      .rot_i       (rot_v),
      .steer_now_i (now_q[w]),
      .ratio_i     (ratio_q),
      .max_steer_i (max_steer_q),
      .max_drive_i (max_drive_q),
      .steer_goal_o(steer_l[w]),
      .drive_goal_o(drive_l[w])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= valid_q[PipeLat];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && valid_q[PipeLat]) begin
      for (int w = 0; w < 4; w++) begin
        steer_o_q[w] <= steer_l[w];
        drive_o_q[w] <= drive_l[w];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign steer_goal_a_o = steer_o_q[0];
  assign steer_goal_b_o = steer_o_q[1];
  assign steer_goal_c_o = steer_o_q[2];
  assign steer_goal_d_o = steer_o_q[3];
  assign drive_goal_a_o = drive_o_q[0];
  assign drive_goal_b_o = drive_o_q[1];
  assign drive_goal_c_o = drive_o_q[2];
  assign drive_goal_d_o = drive_o_q[3];

endmodule
